// ----- design/bcdp_pkg.sv -----
// ----------------------------------------------------------------------------
// bcdp_pkg: shared types and constants for the byte command decompress parser
// Parse phases, queue command format, result kinds and stream constants.
// ----------------------------------------------------------------------------
package bcdp_pkg;

  localparam logic [63:0] MAGIC_WORD   = 64'h0123_4567_89ab_cdef;
  localparam int          FIELD_BYTES  = 8;
  localparam int          CNT_W        = $clog2(FIELD_BYTES);
  localparam int          QUEUE_DEPTH  = 2;

  // command opcodes as they appear in the stream
  localparam logic [7:0] OPC_LITERAL = 8'd1;
  localparam logic [7:0] OPC_SEEK    = 8'd2;
  localparam logic [7:0] OPC_COPY    = 8'd3;

  // result kinds
  localparam logic [2:0] KIND_WRITE  = 3'd0;
  localparam logic [2:0] KIND_COPY   = 3'd1;
  localparam logic [2:0] KIND_ACCEPT = 3'd2;
  localparam logic [2:0] KIND_REJECT = 3'd3;
  localparam logic [2:0] KIND_TRUNC  = 3'd4;

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_SIZE,
    PH_OPCODE,
    PH_LITERAL,
    PH_FIELD_A,
    PH_FIELD_B,
    PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_SEEK,
    CMD_COPY,
    CMD_ACCEPT,
    CMD_REJECT,
    CMD_TRUNC
  } cmd_op_t;

  // a = literal / offset / distance / size, b = copy count
  typedef struct packed {
    cmd_op_t     op;
    logic        eos;
    logic [63:0] a;
    logic [63:0] b;
  } cmd_t;

endpackage

// ----- design/bcdp_front.sv -----
// ----------------------------------------------------------------------------
// bcdp_front: header and command parser
// Gathers little-endian fields byte by byte and pushes one command per
// finished header, literal, operand set or stream end into the queue.
// ----------------------------------------------------------------------------
module bcdp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              stream_valid,
  output logic              stream_ready,
  input  logic [7:0]        stream_byte,
  input  logic              end_of_stream,
  output logic              push_valid,
  input  logic              push_ready,
  output bcdp_pkg::cmd_t    push_cmd
);

  localparam logic [bcdp_pkg::CNT_W-1:0] CNT_LAST = bcdp_pkg::CNT_W'(bcdp_pkg::FIELD_BYTES - 1);

  bcdp_pkg::phase_t              phase, phase_next;
  logic [bcdp_pkg::CNT_W-1:0]    cnt, cnt_next;
  logic [1:0]                    pend, pend_next;
  logic [63:0]                   acc, acc_next;
  logic [63:0]                   held, held_next;

  logic        fire;
  logic        last;
  logic [63:0] word;

  assign stream_ready = push_ready;
  assign fire = stream_valid && stream_ready;
  assign last = (cnt == CNT_LAST);
  assign word = {stream_byte, acc[63:8]};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= bcdp_pkg::PH_MAGIC;
      cnt   <= '0;
      pend  <= '0;
    end else begin
      phase <= phase_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    acc  <= acc_next;
    held <= held_next;
  end

  always_comb begin
    phase_next   = phase;
    cnt_next     = cnt;
    pend_next    = pend;
    acc_next     = acc;
    held_next    = held;
    push_valid   = 1'b0;
    push_cmd.op  = bcdp_pkg::CMD_NONE;
    push_cmd.eos = end_of_stream;
    push_cmd.a   = '0;
    push_cmd.b   = '0;

    if (fire) begin
      case (phase)
        bcdp_pkg::PH_MAGIC: begin
          if (last) begin
            push_valid = 1'b1;
            if (word != bcdp_pkg::MAGIC_WORD) begin
              push_cmd.op = bcdp_pkg::CMD_REJECT;
              phase_next  = bcdp_pkg::PH_SKIP;
            end else if (end_of_stream) begin
              push_cmd.op = bcdp_pkg::CMD_TRUNC;
            end else begin
              push_valid = 1'b0;
              phase_next = bcdp_pkg::PH_SIZE;
              cnt_next   = '0;
            end
          end else if (end_of_stream) begin
            push_valid  = 1'b1;
            push_cmd.op = bcdp_pkg::CMD_TRUNC;
          end else begin
            cnt_next = cnt + 1'b1;
            acc_next = word;
          end
        end
        bcdp_pkg::PH_SIZE: begin
          if (last) begin
            push_valid  = 1'b1;
            push_cmd.op = bcdp_pkg::CMD_ACCEPT;
            push_cmd.a  = word;
            phase_next  = bcdp_pkg::PH_OPCODE;
          end else if (end_of_stream) begin
            push_valid  = 1'b1;
            push_cmd.op = bcdp_pkg::CMD_TRUNC;
          end else begin
            cnt_next = cnt + 1'b1;
            acc_next = word;
          end
        end
        bcdp_pkg::PH_OPCODE: begin
          if (stream_byte inside {bcdp_pkg::OPC_LITERAL, bcdp_pkg::OPC_SEEK,
                                  bcdp_pkg::OPC_COPY}) begin
            if (end_of_stream) begin
              push_valid  = 1'b1;
              push_cmd.op = bcdp_pkg::CMD_TRUNC;
            end else begin
              pend_next  = stream_byte[1:0];
              cnt_next   = '0;
              phase_next = (stream_byte == bcdp_pkg::OPC_LITERAL) ?
                           bcdp_pkg::PH_LITERAL : bcdp_pkg::PH_FIELD_A;
            end
          end else if (end_of_stream) begin
            // no-op byte still has to clear the position tracker
            push_valid = 1'b1;
          end
        end
        bcdp_pkg::PH_LITERAL: begin
          push_valid  = 1'b1;
          push_cmd.op = bcdp_pkg::CMD_WRITE;
          push_cmd.a  = {56'd0, stream_byte};
          phase_next  = bcdp_pkg::PH_OPCODE;
        end
        bcdp_pkg::PH_FIELD_A: begin
          if (last) begin
            if (pend == bcdp_pkg::OPC_SEEK[1:0]) begin
              push_valid  = 1'b1;
              push_cmd.op = end_of_stream ? bcdp_pkg::CMD_NONE : bcdp_pkg::CMD_SEEK;
              push_cmd.a  = word;
              phase_next  = bcdp_pkg::PH_OPCODE;
            end else if (end_of_stream) begin
              push_valid  = 1'b1;
              push_cmd.op = bcdp_pkg::CMD_TRUNC;
            end else begin
              held_next  = word;
              cnt_next   = '0;
              phase_next = bcdp_pkg::PH_FIELD_B;
            end
          end else if (end_of_stream) begin
            push_valid  = 1'b1;
            push_cmd.op = bcdp_pkg::CMD_TRUNC;
          end else begin
            cnt_next = cnt + 1'b1;
            acc_next = word;
          end
        end
        bcdp_pkg::PH_FIELD_B: begin
          if (last) begin
            push_valid  = 1'b1;
            push_cmd.op = bcdp_pkg::CMD_COPY;
            push_cmd.a  = held;
            push_cmd.b  = word;
            phase_next  = bcdp_pkg::PH_OPCODE;
          end else if (end_of_stream) begin
            push_valid  = 1'b1;
            push_cmd.op = bcdp_pkg::CMD_TRUNC;
          end else begin
            cnt_next = cnt + 1'b1;
            acc_next = word;
          end
        end
        default: begin
          // skip: drop bytes until the stream ends
        end
      endcase

      if (end_of_stream) begin
        phase_next = bcdp_pkg::PH_MAGIC;
        cnt_next   = '0;
        pend_next  = '0;
      end
    end
  end

  a_eos_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && end_of_stream |=> phase == bcdp_pkg::PH_MAGIC && cnt == '0)
    else $error("parser did not restart after end of stream");

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> push_ready)
    else $error("command pushed into a full queue");

endmodule

// ----- design/bcdp_queue.sv -----
// ----------------------------------------------------------------------------
// bcdp_queue: command queue between parser and executor
// Small register FIFO; lets the parser run while the executor is stalled.
// ----------------------------------------------------------------------------
module bcdp_queue #(
  parameter int DEPTH = bcdp_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  bcdp_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output bcdp_pkg::cmd_t pop_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  bcdp_pkg::cmd_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue count out of range");

endmodule

// ----- design/bcdp_back.sv -----
// ----------------------------------------------------------------------------
// bcdp_back: command executor
// Tracks the output position and declared size, runs the bound checks and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module bcdp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  bcdp_pkg::cmd_t cmd,
  output logic           result_valid,
  input  logic           result_ready,
  output logic [2:0]     kind,
  output logic [63:0]    dest_addr,
  output logic [7:0]     literal,
  output logic [63:0]    back_distance,
  output logic [63:0]    length,
  output logic           beyond_size
);

  logic [63:0] pos, pos_next;
  logic [63:0] size, size_next;
  logic        take;
  logic        emit;
  logic [2:0]  kind_next;
  logic [63:0] dest_next, dist_next, len_next;
  logic [7:0]  lit_next;
  logic        beyond_next;

  assign cmd_ready = !result_valid || result_ready;
  assign take      = cmd_valid && cmd_ready;

  always_comb begin
    pos_next    = pos;
    size_next   = size;
    emit        = 1'b0;
    kind_next   = bcdp_pkg::KIND_WRITE;
    dest_next   = '0;
    lit_next    = '0;
    dist_next   = '0;
    len_next    = '0;
    beyond_next = 1'b0;
    case (cmd.op)
      bcdp_pkg::CMD_WRITE: begin
        emit        = 1'b1;
        dest_next   = pos;
        lit_next    = cmd.a[7:0];
        beyond_next = (pos >= size);
        pos_next    = pos + 64'd1;
      end
      bcdp_pkg::CMD_SEEK: begin
        pos_next = pos + cmd.a;
      end
      bcdp_pkg::CMD_COPY: begin
        emit        = 1'b1;
        kind_next   = bcdp_pkg::KIND_COPY;
        dest_next   = pos;
        dist_next   = cmd.a;
        len_next    = cmd.b;
        beyond_next = (pos > size) || (cmd.b > size - pos);
        pos_next    = pos + cmd.b;
      end
      bcdp_pkg::CMD_ACCEPT: begin
        emit      = 1'b1;
        kind_next = bcdp_pkg::KIND_ACCEPT;
        len_next  = cmd.a;
        size_next = cmd.a;
      end
      bcdp_pkg::CMD_REJECT: begin
        emit      = 1'b1;
        kind_next = bcdp_pkg::KIND_REJECT;
      end
      bcdp_pkg::CMD_TRUNC: begin
        emit      = 1'b1;
        kind_next = bcdp_pkg::KIND_TRUNC;
        dest_next = pos;
      end
      default: begin
      end
    endcase
    // end of stream: start the next file from scratch
    if (cmd.eos) begin
      pos_next  = '0;
      size_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      size         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (take) begin
        pos  <= pos_next;
        size <= size_next;
      end
      if (take) begin
        result_valid <= emit;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      kind          <= kind_next;
      dest_addr     <= dest_next;
      literal       <= lit_next;
      back_distance <= dist_next;
      length        <= len_next;
      beyond_size   <= beyond_next;
    end
  end

  a_eos_clears_pos: assert property (@(posedge clk) disable iff (rst)
    take && cmd.eos |=> pos == '0 && size == '0)
    else $error("position not cleared at end of stream");

  a_accept_loads_size: assert property (@(posedge clk) disable iff (rst)
    take && cmd.op == bcdp_pkg::CMD_ACCEPT && !cmd.eos |=> size == $past(cmd.a))
    else $error("declared size not loaded");

endmodule

// ----- design/byte_command_decompress_parser_top.sv -----
// ----------------------------------------------------------------------------
// byte_command_decompress_parser_top: literal/copy stream decoder
// Checks the magic word, reads the declared size, then decodes commands into
// byte writes and copy descriptors with bound flags.
//
//   channel   direction  handshake                     payload
//   stream    in         stream_valid / stream_ready   stream_byte, end_of_stream
//   result    out        result_valid / result_ready   kind, dest_addr, literal,
//                                                      back_distance, length,
//                                                      beyond_size
//
// One byte per cycle while the command queue has room; each command is registered
// in the queue and then in the executor's output register before its result is valid.
// The parser takes bytes while the command queue has room, the executor
// drains the queue whenever its output register is free or being taken.
// Reset (rst, synchronous) restarts at the magic word with position zero.
// A stalled result side fills the queue and then drops stream_ready.
// ----------------------------------------------------------------------------
module byte_command_decompress_parser_top #(
  parameter int QUEUE_DEPTH = bcdp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        stream_valid,
  output logic        stream_ready,
  input  logic [7:0]  stream_byte,
  input  logic        end_of_stream,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  kind,
  output logic [63:0] dest_addr,
  output logic [7:0]  literal,
  output logic [63:0] back_distance,
  output logic [63:0] length,
  output logic        beyond_size
);

  logic           push_valid, push_ready;
  bcdp_pkg::cmd_t push_cmd;
  logic           pop_valid, pop_ready;
  bcdp_pkg::cmd_t pop_cmd;

  bcdp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .stream_valid  (stream_valid),
    .stream_ready  (stream_ready),
    .stream_byte   (stream_byte),
    .end_of_stream (end_of_stream),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_cmd      (push_cmd)
  );

  bcdp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  bcdp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (pop_valid),
    .cmd_ready     (pop_ready),
    .cmd           (pop_cmd),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .kind          (kind),
    .dest_addr     (dest_addr),
    .literal       (literal),
    .back_distance (back_distance),
    .length        (length),
    .beyond_size   (beyond_size)
  );

endmodule
